// File: rtl/uv_sphere_vertex_generator_assert.svh
// Assertion macros shared by the checker.
`ifndef UV_SPHERE_VERTEX_GENERATOR_ASSERT_SVH
`define UV_SPHERE_VERTEX_GENERATOR_ASSERT_SVH
`define UVS_ASSERT_IMP(label, clk, rstn, a, c) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");
`define UVS_ASSERT_NXT(label, clk, rstn, a, c) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// File: rtl/uvs_pkg.sv
package uvs_pkg;
  localparam int unsigned MaxSubdivisions = 255;
  localparam logic [7:0] SubdivReset = 8'd48;
  localparam int unsigned CordicSteps = 20;
  localparam logic signed [33:0] CordicOne = 34'sd652032874;
  localparam int unsigned Depth = 30;

  function automatic logic signed [33:0] atan_turn(input int unsigned i);
    logic signed [33:0] t [CordicSteps] = '{
      34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756, 34'sd42667331,
      34'sd21354465, 34'sd10679838, 34'sd5340245, 34'sd2670163, 34'sd1335087,
      34'sd667544, 34'sd333772, 34'sd166886, 34'sd83443, 34'sd41722,
      34'sd20861, 34'sd10430, 34'sd5215, 34'sd2608, 34'sd1304};
    return t[i];
  endfunction

  // Classified point handed from the front end to the back end.
  typedef struct packed {
    logic [7:0] p;
    logic [7:0] ring;
    logic [7:0] seg;
    logic       quad;
  } point_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [15:0] tex_u;
    logic [15:0] tex_v;
    logic        quad_valid;
    logic [15:0] corner_a;
    logic [15:0] corner_b;
    logic [15:0] corner_c;
    logic [15:0] corner_d;
    logic [15:0] corner_e;
    logic [15:0] corner_f;
  } result_t;
endpackage

// File: rtl/uvs_front.sv
// Saturates the grid point and the register and pushes it into a small queue.
module uvs_front #(
  parameter int unsigned MAX_SUBDIVISIONS = uvs_pkg::MaxSubdivisions
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [7:0]     subdiv_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [7:0]     ring_i,
  input  logic [7:0]     segment_i,
  output logic           pt_valid_o,
  input  logic           pt_take_i,
  output uvs_pkg::point_t pt_o
);
  localparam logic [7:0] MaxP = 8'(MAX_SUBDIVISIONS);
  uvs_pkg::point_t q_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic wr_q, wr_d, rd_q, rd_d;
  logic push, pop;
  uvs_pkg::point_t cls;
  logic [7:0] p;

  always_comb begin
    p = (subdiv_i == 8'd0) ? 8'd1 : subdiv_i;
    if (p > MaxP) p = MaxP;
    cls.p = p;
    cls.ring = (ring_i > p) ? p : ring_i;
    cls.seg = (segment_i > p) ? p : segment_i;
    cls.quad = (ring_i < p) && (segment_i < p);
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign push = in_valid_i && !in_stall_o;
  assign pt_valid_o = (cnt_q != 2'd0);
  assign pop = pt_valid_o && pt_take_i;
  assign pt_o = q_q[rd_q];

  always_comb begin
    cnt_d = cnt_q + 2'(push) - 2'(pop);
    wr_d = push ? !wr_q : wr_q;
    rd_d = pop ? !rd_q : rd_q;
  end

  always_ff @(posedge clk_i) begin
    if (push) q_q[wr_q] <= cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; wr_q <= 1'b0; rd_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d; wr_q <= wr_d; rd_q <= rd_d;
    end
  end
endmodule

// File: rtl/uvs_back.sv
// Pipelined datapath: angle division, two CORDICs, products, rounding.
// The whole pipeline advances together whenever its last stage is free.
module uvs_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            pt_valid_i,
  output logic            pt_take_o,
  input  uvs_pkg::point_t pt_i,
  output logic            res_valid_o,
  input  logic            res_stall_i,
  output uvs_pkg::result_t res_o
);
  localparam int unsigned D = uvs_pkg::Depth;
  localparam int unsigned NS = uvs_pkg::CordicSteps;
  // Stages: eight of restoring division (up to six quotient bits each), twenty of
  // CORDIC, one of products and the output register; D counts them all.

  logic [D-1:0] v_q;
  logic adv;
  assign adv = !(v_q[D-1] && res_stall_i);
  assign pt_take_o = adv;
  assign res_valid_o = v_q[D-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (adv) v_q <= {v_q[D-2:0], pt_valid_i};
  end

  // Division section: 8 stages, up to 6 quotient bits each, for four quotients.
  // lat = (ring<<31 + p/2)/p, lon = (seg<<32 + p/2)/p, u,v = (x*32768+p/2)/p.
  localparam int unsigned DS = 8;
  localparam int unsigned QB = 41;
  typedef struct packed {
    logic [7:0]  p;
    logic [7:0]  ring;
    logic [7:0]  seg;
    logic        quad;
    logic [40:0] n_lat, n_lon;
    logic [23:0] n_u, n_v;
    logic [8:0]  r_lat, r_lon, r_u, r_v;
  } dv_t;
  dv_t dv_q [DS+1];

  function automatic logic [8:0] dstep(input logic [8:0] r, input logic b, input logic [7:0] p,
                                       output logic q);
    logic [9:0] t;
    t = {r, b};
    if (t >= {2'b0, p}) begin q = 1'b1; t = t - {2'b0, p}; end
    else q = 1'b0;
    return t[8:0];
  endfunction

  always_comb begin
    dv_q[0].p = pt_i.p;
    dv_q[0].ring = pt_i.ring;
    dv_q[0].seg = pt_i.seg;
    dv_q[0].quad = pt_i.quad;
    dv_q[0].n_lat = {2'b0, pt_i.ring, 31'd0} + {34'd0, pt_i.p[7:1]};
    dv_q[0].n_lon = {1'b0, pt_i.seg, 32'd0} + {34'd0, pt_i.p[7:1]};
    dv_q[0].n_u = {1'b0, pt_i.seg, 15'd0} + {17'd0, pt_i.p[7:1]};
    dv_q[0].n_v = {1'b0, pt_i.ring, 15'd0} + {17'd0, pt_i.p[7:1]};
    dv_q[0].r_lat = '0; dv_q[0].r_lon = '0; dv_q[0].r_u = '0; dv_q[0].r_v = '0;
  end

  for (genvar s = 0; s < DS; s++) begin : g_div
    dv_t nx;
    always_comb begin
      logic q;
      nx = dv_q[s];
      for (int k = 0; k < 6; k++) begin
        if (s * 6 + k < QB) begin
          nx.r_lat = dstep(nx.r_lat, nx.n_lat[40], nx.p, q);
          nx.n_lat = {nx.n_lat[39:0], q};
          nx.r_lon = dstep(nx.r_lon, nx.n_lon[40], nx.p, q);
          nx.n_lon = {nx.n_lon[39:0], q};
        end
        if (s * 6 + k < 24) begin
          nx.r_u = dstep(nx.r_u, nx.n_u[23], nx.p, q);
          nx.n_u = {nx.n_u[22:0], q};
          nx.r_v = dstep(nx.r_v, nx.n_v[23], nx.p, q);
          nx.n_v = {nx.n_v[22:0], q};
        end
      end
    end
    if (s == 0) begin : g_s0
      always_ff @(posedge clk_i) if (adv) dv_q[1] <= nx;
    end else begin : g_sn
      always_ff @(posedge clk_i) if (adv) dv_q[s+1] <= nx;
    end
  end

  // Divider output: after 41 shifts the angle quotients fill the 41-bit registers;
  // the texture quotients take 24 shifts.
  logic [31:0] lat, lon;
  assign lat = dv_q[DS].n_lat[31:0];
  assign lon = dv_q[DS].n_lon[31:0];

  // CORDIC section: one rotation of both angles per stage.
  typedef struct packed {
    logic [7:0]  p;
    logic [7:0]  ring;
    logic [7:0]  seg;
    logic        quad;
    logic [15:0] tu, tv;
    logic        f_a, f_o;
    logic signed [33:0] xa, ya, za, xo, yo, zo;
  } cr_t;
  cr_t cr_q [NS+1];

  function automatic logic signed [33:0] fold(input logic [31:0] a, output logic f);
    logic [31:0] t;
    t = a - 32'h40000000;
    f = (t < 32'h80000000);
    t = f ? a - 32'h80000000 : a;
    return {{2{t[31]}}, t};
  endfunction

  // Truncating arithmetic shift toward zero.
  function automatic logic signed [33:0] sht(input logic signed [33:0] v, input int unsigned n);
    logic signed [33:0] m;
    m = v[33] ? -v : v;
    m = m >>> n;
    return v[33] ? -m : m;
  endfunction

  always_comb begin
    logic f;
    cr_q[0].p = dv_q[DS].p;
    cr_q[0].ring = dv_q[DS].ring;
    cr_q[0].seg = dv_q[DS].seg;
    cr_q[0].quad = dv_q[DS].quad;
    cr_q[0].tu = dv_q[DS].n_u[15:0];
    cr_q[0].tv = dv_q[DS].n_v[15:0];
    cr_q[0].za = fold(lat, f); cr_q[0].f_a = f;
    cr_q[0].zo = fold(lon, f); cr_q[0].f_o = f;
    cr_q[0].xa = uvs_pkg::CordicOne; cr_q[0].ya = '0;
    cr_q[0].xo = uvs_pkg::CordicOne; cr_q[0].yo = '0;
  end

  for (genvar i = 0; i < NS; i++) begin : g_cor
    cr_t nx;
    always_comb begin
      nx = cr_q[i];
      if (!cr_q[i].za[33]) begin
        nx.xa = cr_q[i].xa - sht(cr_q[i].ya, i);
        nx.ya = cr_q[i].ya + sht(cr_q[i].xa, i);
        nx.za = cr_q[i].za - uvs_pkg::atan_turn(i);
      end else begin
        nx.xa = cr_q[i].xa + sht(cr_q[i].ya, i);
        nx.ya = cr_q[i].ya - sht(cr_q[i].xa, i);
        nx.za = cr_q[i].za + uvs_pkg::atan_turn(i);
      end
      if (!cr_q[i].zo[33]) begin
        nx.xo = cr_q[i].xo - sht(cr_q[i].yo, i);
        nx.yo = cr_q[i].yo + sht(cr_q[i].xo, i);
        nx.zo = cr_q[i].zo - uvs_pkg::atan_turn(i);
      end else begin
        nx.xo = cr_q[i].xo + sht(cr_q[i].yo, i);
        nx.yo = cr_q[i].yo - sht(cr_q[i].xo, i);
        nx.zo = cr_q[i].zo + uvs_pkg::atan_turn(i);
      end
    end
    always_ff @(posedge clk_i) if (adv) cr_q[i+1] <= nx;
  end

  // Product stage: 34x34-bit signed products of the sign-corrected CORDIC outputs.
  logic signed [33:0] slat, clat, slon, clon;
  always_comb begin
    slat = cr_q[NS].f_a ? -cr_q[NS].ya : cr_q[NS].ya;
    if (slat[33]) slat = -slat;
    clat = cr_q[NS].f_a ? -cr_q[NS].xa : cr_q[NS].xa;
    slon = cr_q[NS].f_o ? -cr_q[NS].yo : cr_q[NS].yo;
    clon = cr_q[NS].f_o ? -cr_q[NS].xo : cr_q[NS].xo;
  end

  logic signed [67:0] px_q, pz_q;
  logic signed [33:0] ny_q;
  logic [7:0] p_q, ring_q, seg_q;
  logic quad_q;
  logic [15:0] tu_q, tv_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      px_q <= -(clon * slat);
      pz_q <= slon * slat;
      ny_q <= -clat;
      p_q <= cr_q[NS].p; ring_q <= cr_q[NS].ring; seg_q <= cr_q[NS].seg;
      quad_q <= cr_q[NS].quad; tu_q <= cr_q[NS].tu; tv_q <= cr_q[NS].tv;
    end
  end

  function automatic logic signed [15:0] rsat(input logic signed [67:0] v, input int unsigned sh);
    logic signed [67:0] r;
    r = (v + (68'sd1 <<< (sh - 1))) >>> sh;
    if (r > 68'sd32767) return 16'sd32767;
    if (r < -68'sd32768) return -16'sd32768;
    return r[15:0];
  endfunction

  uvs_pkg::result_t r;
  logic [15:0] w, rw, r1w;
  always_comb begin
    w = {8'd0, p_q} + 16'd1;
    rw = 16'(ring_q * w) + {8'd0, seg_q};
    r1w = rw + w;
    r.pos_x = rsat(px_q, 45);
    r.pos_y = rsat({{34{ny_q[33]}}, ny_q}, 15);
    r.pos_z = rsat(pz_q, 45);
    r.tex_u = tu_q;
    r.tex_v = tv_q;
    r.quad_valid = quad_q;
    r.corner_a = quad_q ? rw : '0;
    r.corner_b = quad_q ? rw + 16'd1 : '0;
    r.corner_c = quad_q ? r1w : '0;
    r.corner_d = quad_q ? rw + 16'd1 : '0;
    r.corner_e = quad_q ? r1w + 16'd1 : '0;
    r.corner_f = quad_q ? r1w : '0;
  end

  always_ff @(posedge clk_i) if (adv) res_o <= r;
endmodule

// File: rtl/uv_sphere_vertex_generator.sv
// UV sphere vertex generator: one grid point (ring, segment) in, one vertex word out
// with Q1.15 position/normal, texture coordinates and the quad's six indices. Sustained
// rate is one word per cycle while the output is not stalled. A result word passes
// through the two-entry input queue, eight divider stages, twenty dual CORDIC stages,
// a product stage and the output register. A stalled output freezes the whole pipeline,
// and the input stalls once the queue holds two words. The subdivisions register resets
// to 48 and is to be written only while idle; the block itself does not enforce this.
module uv_sphere_vertex_generator #(
  parameter int unsigned MAX_SUBDIVISIONS = uvs_pkg::MaxSubdivisions
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  ring_i,
  input  logic [7:0]  segment_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [15:0] pos_x_o,
  output logic signed [15:0] pos_y_o,
  output logic signed [15:0] pos_z_o,
  output logic [15:0] tex_u_o,
  output logic [15:0] tex_v_o,
  output logic        quad_valid_o,
  output logic [15:0] corner_a_o,
  output logic [15:0] corner_b_o,
  output logic [15:0] corner_c_o,
  output logic [15:0] corner_d_o,
  output logic [15:0] corner_e_o,
  output logic [15:0] corner_f_o
);
  logic [7:0] subdiv_q;
  logic pt_valid, pt_take;
  uvs_pkg::point_t pt;
  uvs_pkg::result_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) subdiv_q <= uvs_pkg::SubdivReset;
    else if (cfg_we_i) subdiv_q <= cfg_wdata_i;
  end

  uvs_front #(.MAX_SUBDIVISIONS(MAX_SUBDIVISIONS)) u_front (
    .clk_i, .rst_ni, .subdiv_i(subdiv_q), .in_valid_i, .in_stall_o,
    .ring_i, .segment_i, .pt_valid_o(pt_valid), .pt_take_i(pt_take), .pt_o(pt)
  );

  uvs_back u_back (
    .clk_i, .rst_ni, .pt_valid_i(pt_valid), .pt_take_o(pt_take), .pt_i(pt),
    .res_valid_o(out_valid_o), .res_stall_i(out_stall_i), .res_o(res)
  );

  assign pos_x_o = res.pos_x;
  assign pos_y_o = res.pos_y;
  assign pos_z_o = res.pos_z;
  assign tex_u_o = res.tex_u;
  assign tex_v_o = res.tex_v;
  assign quad_valid_o = res.quad_valid;
  assign corner_a_o = res.corner_a;
  assign corner_b_o = res.corner_b;
  assign corner_c_o = res.corner_c;
  assign corner_d_o = res.corner_d;
  assign corner_e_o = res.corner_e;
  assign corner_f_o = res.corner_f;
endmodule

// File: rtl/uvs_checker.sv
`include "uv_sphere_vertex_generator_assert.svh"
// Port-level checks of the vertex generator.
module uvs_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic quad_valid_o,
  input logic [15:0] corner_a_o,
  input logic [15:0] corner_b_o,
  input logic [15:0] corner_d_o,
  input logic [15:0] tex_u_o
);
  `UVS_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(corner_a_o))
  `UVS_ASSERT_IMP(a_bd, clk_i, rst_ni, out_valid_o, corner_b_o == corner_d_o)
  `UVS_ASSERT_IMP(a_zero, clk_i, rst_ni, out_valid_o && !quad_valid_o, corner_a_o == 16'd0)
  `UVS_ASSERT_IMP(a_tex, clk_i, rst_ni, out_valid_o, tex_u_o <= 16'd32768)
endmodule

bind uv_sphere_vertex_generator uvs_checker u_chk (.*);

// File: tb/tb_uv_sphere_vertex_generator.sv
`timescale 1ns / 100ps

module tb_uv_sphere_vertex_generator;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned CycleLimit = 200000;

  typedef struct {
    int unsigned ring;
    int unsigned seg;
    bit          typed;
    int unsigned tex_u;
    int unsigned tex_v;
    int unsigned quad;
    int unsigned corner_a;
  } grid_row_t;

  // Rows are for the reset value of 48 subdivisions.
  grid_row_t grid_rows [12] = '{
    '{0, 0, 1, 0, 0, 1, 0},
    '{47, 47, 1, 32085, 32085, 1, 2350},
    '{48, 48, 1, 32768, 32768, 0, 0},
    '{255, 255, 1, 32768, 32768, 0, 0},
    '{0, 48, 1, 32768, 0, 1'b0, 0},
    '{24, 12, 1, 8192, 16384, 1, 1188},
    '{255, 0, 0, 0, 0, 0, 0},
    '{0, 255, 0, 0, 0, 0, 0},
    '{1, 1, 0, 0, 0, 0, 0},
    '{12, 36, 0, 0, 0, 0, 0},
    '{36, 24, 0, 0, 0, 0, 0},
    '{47, 0, 0, 0, 0, 0, 0}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [7:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  ring_i;
  logic [7:0]  segment_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic signed [15:0] pos_x_o;
  logic signed [15:0] pos_y_o;
  logic signed [15:0] pos_z_o;
  logic [15:0] tex_u_o;
  logic [15:0] tex_v_o;
  logic        quad_valid_o;
  logic [15:0] corner_a_o;
  logic [15:0] corner_b_o;
  logic [15:0] corner_c_o;
  logic [15:0] corner_d_o;
  logic [15:0] corner_e_o;
  logic [15:0] corner_f_o;

  uvs_pkg::result_t vertex_q [$];
  logic [7:0]  subdiv_reg;
  int unsigned sender_idle;
  int unsigned receiver_idle;
  int unsigned errors;
  int unsigned cycles;

  uv_sphere_vertex_generator dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .ring_i(ring_i), .segment_i(segment_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .pos_x_o(pos_x_o), .pos_y_o(pos_y_o), .pos_z_o(pos_z_o),
    .tex_u_o(tex_u_o), .tex_v_o(tex_v_o), .quad_valid_o(quad_valid_o),
    .corner_a_o(corner_a_o), .corner_b_o(corner_b_o), .corner_c_o(corner_c_o),
    .corner_d_o(corner_d_o), .corner_e_o(corner_e_o), .corner_f_o(corner_f_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic void cordic_sin_cos(input logic [31:0] turn, output longint s,
                                         output longint c);
    longint x, y, z, nx;
    bit flip;
    logic [31:0] off;
    flip = 1'b0;
    off = turn - 32'h4000_0000;
    // Fold the angle into the quarter turn either side of zero.
    if (off < 32'h8000_0000) begin
      turn = turn - 32'h8000_0000;
      flip = 1'b1;
    end
    z = longint'($signed(turn));
    x = longint'(uvs_pkg::CordicOne);
    y = 0;
    for (int i = 0; i < uvs_pkg::CordicSteps; i++) begin
      if (z >= 0) begin
        nx = x - y / (longint'(1) << i);
        y = y + x / (longint'(1) << i);
        z = z - longint'(uvs_pkg::atan_turn(i));
      end else begin
        nx = x + y / (longint'(1) << i);
        y = y - x / (longint'(1) << i);
        z = z + longint'(uvs_pkg::atan_turn(i));
      end
      x = nx;
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic logic [15:0] round_q15(input longint v, input int unsigned sh);
    longint r;
    r = (v + (longint'(1) << (sh - 1))) >>> sh;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic uvs_pkg::result_t vertex_of(input logic [7:0] ring,
                                                 input logic [7:0] seg);
    uvs_pkg::result_t v;
    longint p, rg, sg, w, slat, clat, slon, clon;
    logic [63:0] lat, lon;
    p = (subdiv_reg == 0) ? 1 : subdiv_reg;
    rg = (ring > p) ? p : ring;
    sg = (seg > p) ? p : seg;
    lat = ((rg << 31) + p / 2) / p;
    lon = ((sg << 32) + p / 2) / p;
    cordic_sin_cos(lat[31:0], slat, clat);
    cordic_sin_cos(lon[31:0], slon, clon);
    if (slat < 0) slat = -slat;
    v = '0;
    v.pos_x = round_q15(-(clon * slat), 45);
    v.pos_y = round_q15(-clat, 15);
    v.pos_z = round_q15(slon * slat, 45);
    v.tex_u = 16'((sg * 32768 + p / 2) / p);
    v.tex_v = 16'((rg * 32768 + p / 2) / p);
    if (rg < p && sg < p) begin
      w = p + 1;
      v.quad_valid = 1'b1;
      v.corner_a = 16'(rg * w + sg);
      v.corner_b = 16'(rg * w + sg + 1);
      v.corner_c = 16'((rg + 1) * w + sg);
      v.corner_d = 16'(rg * w + sg + 1);
      v.corner_e = 16'((rg + 1) * w + sg + 1);
      v.corner_f = 16'((rg + 1) * w + sg);
    end
    return v;
  endfunction

  // Present one grid point and hold it until accepted; valid stays high afterward.
  task automatic send_point(input logic [7:0] ring, input logic [7:0] seg,
                            input grid_row_t row, input bit use_row);
    uvs_pkg::result_t v;
    while ($urandom_range(99) < sender_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    ring_i <= ring;
    segment_i <= seg;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    v = vertex_of(ring, seg);
    if (use_row && row.typed) begin
      v.tex_u = 16'(row.tex_u);
      v.tex_v = 16'(row.tex_v);
      v.quad_valid = row.quad[0];
      v.corner_a = 16'(row.corner_a);
    end
    vertex_q.insert(vertex_q.size(), v);
  endtask

  task automatic drain_outputs();
    in_valid_i <= 1'b0;
    while (vertex_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_subdivisions(input logic [7:0] value);
    drain_outputs();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    subdiv_reg = value;
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(99) < receiver_idle);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (vertex_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual tex_u %0d tex_v %0d",
                 $realtime, tex_u_o, tex_v_o);
        errors++;
      end else begin
        uvs_pkg::result_t v;
        v = vertex_q.pop_front();
        check_field("pos_x", v.pos_x, pos_x_o);
        check_field("pos_y", v.pos_y, pos_y_o);
        check_field("pos_z", v.pos_z, pos_z_o);
        check_field("tex_u", v.tex_u, tex_u_o);
        check_field("tex_v", v.tex_v, tex_v_o);
        check_field("quad_valid", {15'd0, v.quad_valid}, {15'd0, quad_valid_o});
        check_field("corner_a", v.corner_a, corner_a_o);
        check_field("corner_b", v.corner_b, corner_b_o);
        check_field("corner_c", v.corner_c, corner_c_o);
        check_field("corner_d", v.corner_d, corner_d_o);
        check_field("corner_e", v.corner_e, corner_e_o);
        check_field("corner_f", v.corner_f, corner_f_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic [7:0] subdiv_set [6] = '{8'd0, 8'd1, 8'd255, 8'd7, 8'd48, 8'd2};
    grid_row_t none;
    int unsigned lim;
    none = '{0, 0, 0, 0, 0, 0, 0};
    errors = 0;
    subdiv_reg = uvs_pkg::SubdivReset;
    sender_idle = 31;
    receiver_idle = 61;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i <= 1'b0;
    ring_i <= '0;
    segment_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (grid_rows[i]) begin
      send_point(grid_rows[i].ring, grid_rows[i].seg, grid_rows[i], 1'b1);
    end

    for (int ph = 0; ph < 6; ph++) begin
      // Idling pattern changes every two settings: receiver-heavy, sender-heavy, none.
      sender_idle = (ph < 2) ? 31 : (ph < 4) ? 61 : 0;
      receiver_idle = (ph < 2) ? 61 : (ph < 4) ? 31 : 0;
      write_subdivisions((ph == 3) ? 8'($urandom_range(3, 254)) : subdiv_set[ph]);
      lim = (subdiv_reg > 254) ? 255 : subdiv_reg + 1;
      for (int n = 0; n < 115; n++) begin
        // Most points lie on the grid or one step past it; the rest span the full range.
        if ($urandom_range(9) < 8) begin
          send_point(8'($urandom_range(lim)), 8'($urandom_range(lim)), none, 1'b0);
        end else begin
          send_point(8'($urandom_range(255)), 8'($urandom_range(255)), none, 1'b0);
        end
      end
    end

    drain_outputs();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
